// ----- rtl/core/sdrs_pkg.sv -----
// Shared types and constants for the shortest-seek-first request scheduler.
// No dependencies; sdrs_ctrl, sdrs_dpath and the top level in rtl/core import this package.
`default_nettype none
package sdrs_pkg;

   localparam int TRACK_W = 16;
   localparam int ID_W    = 4;
   localparam int MODE_W  = 2;
   localparam int KIND_W  = 2;
   localparam int CFG_W   = 5;
   localparam int COUNT_W = 5;
   localparam int DATA_W  = 32;
   localparam int PADDR_W = 3;

   localparam logic [MODE_W-1:0] MODE_REQUEST = 2'd0;
   localparam logic [MODE_W-1:0] MODE_FINISH  = 2'd1;

   localparam logic [KIND_W-1:0] KIND_ACCEPT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REJECT = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SERVED = 2'd2;
   localparam logic [KIND_W-1:0] KIND_NONE   = 2'd3;

   localparam logic REG_MAX_QUEUE      = 1'b0;
   localparam logic REG_NUM_REQUESTERS = 1'b1;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [ID_W-1:0]    requester_id;
      logic [TRACK_W-1:0] track;
   } req_type;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [TRACK_W-1:0] served_track;
      logic [ID_W-1:0]    served_requester;
      logic [COUNT_W-1:0] queue_count;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [TRACK_W-1:0] track;
      logic [ID_W-1:0]    owner;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RECOUNT,
      ST_UPDATE,
      ST_DECIDE,
      ST_SCAN,
      ST_SERVE,
      ST_SHIFT
   } state_type;

   typedef struct packed {
      logic load;
      logic recount_init;
      logic recount;
      logic update;
      logic report;
      logic scan;
      logic serve;
      logic shift;
   } cmd_type;

   typedef struct packed {
      logic serve;
      logic walk_done;
      logic recount_done;
   } status_type;

endpackage
`default_nettype wire

// ----- rtl/core/sdrs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none
module sdrs_ram #(
   parameter int WIDTH  = 20,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- rtl/core/sdrs_ctrl.sv -----
// Sequencing state machine of the scheduler: issues datapath commands.
// Depends on sdrs_pkg.
`default_nettype none
module sdrs_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic                nreq_wr,
   input  wire sdrs_pkg::status_type status,
   output sdrs_pkg::cmd_type        cmd,
   output logic                     busy
);
   import sdrs_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (nreq_wr) begin
               state_in = ST_RECOUNT;
            end else if (start) begin
               state_in = ST_UPDATE;
            end
         end
         ST_RECOUNT: begin
            if (status.recount_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_UPDATE: state_in = ST_DECIDE;
         ST_DECIDE: state_in = status.serve ? ST_SCAN : ST_IDLE;
         ST_SCAN: begin
            if (status.walk_done) begin
               state_in = ST_SERVE;
            end
         end
         ST_SERVE: state_in = ST_SHIFT;
         ST_SHIFT: begin
            if (status.walk_done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy             = 1'b0;
            cmd.recount_init = nreq_wr;
            cmd.load         = start & ~nreq_wr;
         end
         ST_RECOUNT: cmd.recount = 1'b1;
         ST_UPDATE:  cmd.update  = 1'b1;
         ST_DECIDE:  cmd.report  = 1'b1;
         ST_SCAN:    cmd.scan    = 1'b1;
         ST_SERVE:   cmd.serve   = 1'b1;
         ST_SHIFT:   cmd.shift   = 1'b1;
         default:    busy        = 1'b1;
      endcase
   end

endmodule
`default_nettype wire

// ----- rtl/core/sdrs_dpath.sv -----
// Datapath of the scheduler: queue RAM, requester flags and counters,
// nearest-track scan, queue compaction and result register.
// Depends on sdrs_pkg and sdrs_ram.
`default_nettype none
module sdrs_dpath #(
   parameter int QUEUE_DEPTH    = 16,
   parameter int MAX_REQUESTERS = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire sdrs_pkg::cmd_type           cmd,
   input  wire sdrs_pkg::req_type           req_data,
   input  wire logic [sdrs_pkg::COUNT_W-1:0] mq_eff,
   input  wire logic [sdrs_pkg::COUNT_W-1:0] nreq_eff,
   output sdrs_pkg::status_type             status,
   output logic                             rsp_valid,
   output sdrs_pkg::rsp_type                rsp_data
);
   import sdrs_pkg::*;

   localparam int AW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int RIW = (MAX_REQUESTERS > 1) ? $clog2(MAX_REQUESTERS) : 1;
   localparam int EW  = TRACK_W + ID_W;

   // control state
   logic [COUNT_W-1:0]        count_ff, count_in;
   logic [TRACK_W-1:0]        head_ff, head_in;
   logic [MAX_REQUESTERS-1:0] out_ff, out_in;
   logic [MAX_REQUESTERS-1:0] done_ff, done_in;
   logic [COUNT_W-1:0]        fin_ff, fin_in;
   logic [COUNT_W-1:0]        live_ff, live_in;
   logic [COUNT_W-1:0]        rc_ff, rc_in;
   logic [COUNT_W-1:0]        ptr_ff, ptr_in;
   logic [COUNT_W-1:0]        lim_ff, lim_in;
   logic                      rd_valid_ff, rd_valid_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   // payload
   req_type            item_ff, item_in;
   logic               acc_ff, acc_in;
   logic [COUNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic [TRACK_W-1:0] best_ff, best_in;
   logic [COUNT_W-1:0] pos_ff, pos_in;
   entry_type          pick_ff, pick_in;
   rsp_type            rsp_ff, rsp_in;

   logic               ram_wr_en;
   logic [AW-1:0]      ram_wr_addr;
   logic [EW-1:0]      ram_wr_data;
   logic [EW-1:0]      ram_rd_data;
   entry_type          rd_entry;
   entry_type          new_entry;

   logic               id_ok;
   logic [RIW-1:0]     id_idx;
   logic               acc_now;
   logic               serve_now;
   logic [COUNT_W:0]   taken;
   logic [TRACK_W-1:0] seek_len;
   logic [RIW-1:0]     own_idx;
   logic [RIW-1:0]     rc_idx;
   logic               walk;

   sdrs_ram #(
      .WIDTH (EW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (AW'(ptr_ff)),
      .rd_data (ram_rd_data)
   );

   assign rd_entry = entry_type'(ram_rd_data);
   assign id_ok    = {1'b0, item_ff.requester_id} < nreq_eff;
   assign id_idx   = RIW'(item_ff.requester_id);
   assign own_idx  = RIW'(pick_ff.owner);
   assign rc_idx   = RIW'(rc_ff);
   assign walk     = cmd.scan | cmd.shift;
   assign acc_now  = id_ok && !done_ff[id_idx] && !out_ff[id_idx] && (count_ff < mq_eff);

   // requesters either finished or holding an entry; the rest are free and live
   assign taken     = {1'b0, fin_ff} + {1'b0, live_ff};
   assign serve_now = (count_ff != '0) &&
                      !((count_ff < mq_eff) && (fin_ff < nreq_eff) &&
                        (taken < {1'b0, nreq_eff}));

   assign seek_len = (rd_entry.track >= head_ff) ? rd_entry.track - head_ff
                                                 : head_ff - rd_entry.track;

   assign new_entry.track = item_ff.track;
   assign new_entry.owner = item_ff.requester_id;

   assign ram_wr_en   = (cmd.update && (item_ff.mode == MODE_REQUEST) && acc_now) ||
                        (cmd.shift && rd_valid_ff);
   assign ram_wr_addr = cmd.shift ? AW'(rd_idx_ff - 1'b1) : AW'(count_ff);
   assign ram_wr_data = cmd.shift ? ram_rd_data : EW'(new_entry);

   assign status.serve        = serve_now;
   assign status.walk_done    = (ptr_ff == lim_ff) && !rd_valid_ff;
   assign status.recount_done = (rc_ff == nreq_eff);

   always_comb begin
      count_in     = count_ff;
      head_in      = head_ff;
      out_in       = out_ff;
      done_in      = done_ff;
      fin_in       = fin_ff;
      live_in      = live_ff;
      rc_in        = rc_ff;
      ptr_in       = ptr_ff;
      lim_in       = lim_ff;
      rd_valid_in  = 1'b0;
      rd_idx_in    = rd_idx_ff;
      rsp_valid_in = 1'b0;
      item_in      = item_ff;
      acc_in       = acc_ff;
      best_in      = best_ff;
      pos_in       = pos_ff;
      pick_in      = pick_ff;
      rsp_in       = rsp_ff;

      if (cmd.load) begin
         item_in = req_data;
      end

      if (cmd.recount_init) begin
         rc_in   = '0;
         fin_in  = '0;
         live_in = '0;
      end

      if (cmd.recount && (rc_ff < nreq_eff)) begin
         rc_in = rc_ff + 1'b1;
         if (done_ff[rc_idx]) begin
            fin_in = fin_ff + 1'b1;
         end else if (out_ff[rc_idx]) begin
            live_in = live_ff + 1'b1;
         end
      end

      if (cmd.update) begin
         acc_in = 1'b0;
         case (item_ff.mode)
            MODE_REQUEST: begin
               if (acc_now) begin
                  acc_in         = 1'b1;
                  count_in       = count_ff + 1'b1;
                  out_in[id_idx] = 1'b1;
                  live_in        = live_ff + 1'b1;
               end
            end
            MODE_FINISH: begin
               if (id_ok && !done_ff[id_idx]) begin
                  done_in[id_idx] = 1'b1;
                  fin_in          = fin_ff + 1'b1;
                  if (out_ff[id_idx]) begin
                     live_in = live_ff - 1'b1;
                  end
               end
            end
            default: acc_in = 1'b0;
         endcase
      end

      if (cmd.report) begin
         ptr_in = '0;
         lim_in = count_ff;
         rsp_in.served_track     = '0;
         rsp_in.served_requester = '0;
         rsp_in.queue_count      = count_ff;
         if (item_ff.mode == MODE_REQUEST) begin
            rsp_valid_in = 1'b1;
            rsp_in.kind  = acc_ff ? KIND_ACCEPT : KIND_REJECT;
            rsp_in.last  = !serve_now;
         end else if (!serve_now) begin
            rsp_valid_in = 1'b1;
            rsp_in.kind  = KIND_NONE;
            rsp_in.last  = 1'b1;
         end
      end

      // issue one queue read a cycle; the data returns in the next cycle
      if (walk && (ptr_ff < lim_ff)) begin
         ptr_in      = ptr_ff + 1'b1;
         rd_valid_in = 1'b1;
         rd_idx_in   = ptr_ff;
      end

      // strict compare keeps the oldest entry on a tie
      if (cmd.scan && rd_valid_ff) begin
         if ((rd_idx_ff == '0) || (seek_len < best_ff)) begin
            best_in = seek_len;
            pos_in  = rd_idx_ff;
            pick_in = rd_entry;
         end
      end

      if (cmd.serve) begin
         head_in          = pick_ff.track;
         count_in         = count_ff - 1'b1;
         ptr_in           = pos_ff + 1'b1;
         out_in[own_idx]  = 1'b0;
         if (({1'b0, pick_ff.owner} < nreq_eff) && !done_ff[own_idx] && out_ff[own_idx]) begin
            live_in = live_ff - 1'b1;
         end
         rsp_valid_in            = 1'b1;
         rsp_in.kind             = KIND_SERVED;
         rsp_in.served_track     = pick_ff.track;
         rsp_in.served_requester = pick_ff.owner;
         rsp_in.queue_count      = count_ff - 1'b1;
         rsp_in.last             = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         head_ff      <= '0;
         out_ff       <= '0;
         done_ff      <= '0;
         fin_ff       <= '0;
         live_ff      <= '0;
         rc_ff        <= '0;
         ptr_ff       <= '0;
         lim_ff       <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         head_ff      <= head_in;
         out_ff       <= out_in;
         done_ff      <= done_in;
         fin_ff       <= fin_in;
         live_ff      <= live_in;
         rc_ff        <= rc_in;
         ptr_ff       <= ptr_in;
         lim_ff       <= lim_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      acc_ff    <= acc_in;
      rd_idx_ff <= rd_idx_in;
      best_ff   <= best_in;
      pos_ff    <= pos_in;
      pick_ff   <= pick_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

// ----- rtl/core/sstf_disk_request_scheduler.sv -----
// Top level of the shortest-seek-first disk request scheduler: register port,
// controller and datapath. Depends on sdrs_pkg, sdrs_ctrl, sdrs_dpath, sdrs_ram.
//
// Items are taken with start while busy is low; each one is a request, a finish
// mark or a poll. Results come back on rsp_valid/rsp_data for one cycle each and
// cannot be held off, so the receiver must take every strobe. A request gives an
// accept or reject result and, if service follows, a served result; a finish mark
// or poll gives exactly one result. rsp_data.last marks the final result of an
// item. Without service an item goes through the update and decide states before
// the next possible transfer. With service the queue RAM is read one entry a
// cycle to find the nearest track, then the entries behind the served one are
// moved down one a cycle; both walks go through the single read port of the
// queue memory. Writing num_requesters starts a recount of the requester flags
// that holds busy high, from the write cycle on, until every flag below the
// saturated requester count is counted. Registers sit at byte address 0
// (max_queue) and 4 (num_requesters).
`default_nettype none
module sstf_disk_request_scheduler #(
   parameter int QUEUE_DEPTH    = 16,
   parameter int MAX_REQUESTERS = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire sdrs_pkg::req_type           req_data,
   output logic                             rsp_valid,
   output sdrs_pkg::rsp_type                rsp_data,
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [sdrs_pkg::PADDR_W-1:0] paddr,
   input  wire logic [sdrs_pkg::DATA_W-1:0]  pwdata,
   output logic      [sdrs_pkg::DATA_W-1:0]  prdata,
   output logic                             pready
);
   import sdrs_pkg::*;

   localparam int QD_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int NR_W   = $clog2(MAX_REQUESTERS + 1);
   localparam int SATQ_W = (QD_W > CFG_W) ? QD_W : CFG_W;
   localparam int SATR_W = (NR_W > CFG_W) ? NR_W : CFG_W;

   logic [CFG_W-1:0]   mq_cfg_ff, mq_cfg_in;
   logic [CFG_W-1:0]   nreq_cfg_ff, nreq_cfg_in;
   logic [COUNT_W-1:0] mq_eff;
   logic [COUNT_W-1:0] nreq_eff;
   logic               csr_wr;
   logic               nreq_wr;
   logic               ctrl_busy;
   cmd_type            cmd;
   status_type         status;

   // register port: write on the access phase, no wait states
   assign pready  = 1'b1;
   assign csr_wr  = psel & penable & pwrite & pready;
   assign nreq_wr = csr_wr & (paddr[2] == REG_NUM_REQUESTERS);

   always_comb begin
      mq_cfg_in   = mq_cfg_ff;
      nreq_cfg_in = nreq_cfg_ff;
      if (csr_wr) begin
         case (paddr[2])
            REG_MAX_QUEUE:      mq_cfg_in   = pwdata[CFG_W-1:0];
            REG_NUM_REQUESTERS: nreq_cfg_in = pwdata[CFG_W-1:0];
            default:            mq_cfg_in   = mq_cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mq_cfg_ff   <= CFG_W'(16);
         nreq_cfg_ff <= CFG_W'(16);
      end else begin
         mq_cfg_ff   <= mq_cfg_in;
         nreq_cfg_ff <= nreq_cfg_in;
      end
   end

   always_comb begin
      case (paddr[2])
         REG_MAX_QUEUE:      prdata = DATA_W'(mq_cfg_ff);
         REG_NUM_REQUESTERS: prdata = DATA_W'(nreq_cfg_ff);
         default:            prdata = '0;
      endcase
   end

   // clamp register values to the range the storage supports
   always_comb begin
      if (mq_cfg_ff == '0) begin
         mq_eff = COUNT_W'(1);
      end else if (SATQ_W'(mq_cfg_ff) > SATQ_W'(QUEUE_DEPTH)) begin
         mq_eff = COUNT_W'(QUEUE_DEPTH);
      end else begin
         mq_eff = COUNT_W'(mq_cfg_ff);
      end
      if (nreq_cfg_ff == '0) begin
         nreq_eff = COUNT_W'(1);
      end else if (SATR_W'(nreq_cfg_ff) > SATR_W'(MAX_REQUESTERS)) begin
         nreq_eff = COUNT_W'(MAX_REQUESTERS);
      end else begin
         nreq_eff = COUNT_W'(nreq_cfg_ff);
      end
   end

   // hold off a transfer in the cycle that rewrites the requester count
   assign busy = ctrl_busy | nreq_wr;

   sdrs_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .nreq_wr (nreq_wr),
      .status  (status),
      .cmd     (cmd),
      .busy    (ctrl_busy)
   );

   sdrs_dpath #(
      .QUEUE_DEPTH    (QUEUE_DEPTH),
      .MAX_REQUESTERS (MAX_REQUESTERS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .mq_eff    (mq_eff),
      .nreq_eff  (nreq_eff),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // an accepted item always keeps the block busy in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("block idle right after an item transfer");

   // no two results, of one item or of different items, are in adjacent cycles
   a_result_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("results on adjacent cycles");

   // an accepted request leaves the queue non-empty and within its limit
   a_accept_room: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.kind == KIND_ACCEPT)) |->
         (rsp_data.queue_count != '0) && (rsp_data.queue_count <= mq_eff))
      else $error("accepted request beyond queue limit");

   // served and nothing-done results always close out their item
   a_final_kinds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && ((rsp_data.kind == KIND_SERVED) || (rsp_data.kind == KIND_NONE)))
         |-> rsp_data.last)
      else $error("served or idle result not marked last");

endmodule
`default_nettype wire

// ----- sim/tb_sstf_disk_request_scheduler.sv -----
// Self-checking testbench for the shortest-seek-first disk request scheduler.
// Needs sdrs_pkg and the sstf_disk_request_scheduler RTL; predicts every result
// in-line and checks each response strobe against the oldest pending prediction.
module tb_sstf_disk_request_scheduler;
   timeunit 1ns;
   timeprecision 1ps;

   import sdrs_pkg::*;

   localparam int QUEUE_DEPTH    = 16;
   localparam int MAX_REQUESTERS = 16;
   localparam int RESET_CYCLES   = 11;
   localparam int MAX_GAP        = 4;
   // Give the block margin past the worst service of a full queue.
   localparam int SETTLE_CYCLES  = 48;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PHASE_ITEMS    = 138;
   localparam int NUM_PHASES     = 10;

   // The package names only request and finish; the other two codes both poll.
   localparam logic [MODE_W-1:0] MODE_POLL  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

   // Register settings for the random phases. Out-of-range values (0, 17..31)
   // are included on purpose: the block saturates them.
   localparam int unsigned PHASE_MAX_QUEUE[NUM_PHASES]  = '{16, 1, 0, 31, 7, 3, 16, 2, 5, 12};
   localparam int unsigned PHASE_REQUESTERS[NUM_PHASES] = '{16, 16, 31, 16, 12, 5, 1, 0, 3, 8};

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   req_type             req_data;
   logic                rsp_valid;
   rsp_type             rsp_data;
   logic                psel;
   logic                penable;
   logic                pwrite;
   logic [PADDR_W-1:0]  paddr;
   logic [DATA_W-1:0]   pwdata;
   logic [DATA_W-1:0]   prdata;
   logic                pready;

   // Scheduler shadow state, updated at each accepted transfer.
   logic [CFG_W-1:0]    cfg_max_queue  = 5'd16;
   logic [CFG_W-1:0]    cfg_requesters = 5'd16;
   logic [TRACK_W-1:0]  queue_track[QUEUE_DEPTH];
   logic [ID_W-1:0]     queue_owner[QUEUE_DEPTH];
   int unsigned         queued = 0;
   logic [TRACK_W-1:0]  head_position = '0;
   bit                  owes_entry[MAX_REQUESTERS];
   bit                  retired[MAX_REQUESTERS];

   rsp_type             pending_results[$];
   int                  mismatch_count = 0;
   int                  stall_cycles = 0;
   rsp_type             oldest_result;
   bit                  gapless = 1'b0;
   // Requesters at or above this id may have been marked finished; finish marks
   // only ever lower it by one, so low ids stay live for most of the run.
   int unsigned         retire_floor = MAX_REQUESTERS;

   sstf_disk_request_scheduler #(
      .QUEUE_DEPTH    (QUEUE_DEPTH),
      .MAX_REQUESTERS (MAX_REQUESTERS)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------------

   // Registers are used saturated to 1..top.
   function automatic int unsigned clamp_setting(logic [CFG_W-1:0] raw, int unsigned top);
      if (raw == 0) return 1;
      if (raw > top) return top;
      return raw;
   endfunction

   // Append one predicted result behind the ones still pending.
   task automatic post_result(input rsp_type r);
      pending_results = {pending_results, r};
   endtask

   // Apply one accepted item to the shadow state and queue its results: the
   // accept/reject verdict for a request, then a service if one is forced.
   task automatic schedule_item(input req_type item);
      int unsigned nreq;
      int unsigned limit;
      int unsigned finished;
      int unsigned free_live;
      int unsigned pos;
      int unsigned best;
      int unsigned seek_len;
      int unsigned i;
      bit          serve;
      rsp_type     res;
      logic [KIND_W-1:0] verdict;
      nreq      = clamp_setting(cfg_requesters, MAX_REQUESTERS);
      limit     = clamp_setting(cfg_max_queue, QUEUE_DEPTH);
      finished  = 0;
      free_live = 0;
      verdict   = KIND_REJECT;
      if (item.mode == MODE_REQUEST) begin
         if (item.requester_id < nreq && !retired[item.requester_id] &&
             !owes_entry[item.requester_id] && queued < limit) begin
            queue_track[queued] = item.track;
            queue_owner[queued] = item.requester_id;
            queued++;
            owes_entry[item.requester_id] = 1'b1;
            verdict = KIND_ACCEPT;
         end
      end else if (item.mode == MODE_FINISH && item.requester_id < nreq) begin
         retired[item.requester_id] = 1'b1;
      end

      // Finished requesters are left out of the free count.
      for (i = 0; i < nreq; i++) begin
         if (retired[i]) finished++;
         else if (!owes_entry[i]) free_live++;
      end
      serve = queued > 0 && !(queued < limit && finished < nreq && free_live > 0);

      if (item.mode == MODE_REQUEST) begin
         res             = '0;
         res.kind        = verdict;
         res.queue_count = COUNT_W'(queued);
         res.last        = !serve;
         post_result(res);
      end
      if (serve) begin
         // Nearest track to the head; strict compare keeps the oldest on a tie.
         pos  = 0;
         best = 0;
         for (i = 0; i < queued; i++) begin
            seek_len = (queue_track[i] >= head_position) ? queue_track[i] - head_position
                                                          : head_position - queue_track[i];
            if (i == 0 || seek_len < best) begin
               best = seek_len;
               pos  = i;
            end
         end
         res                  = '0;
         res.kind             = KIND_SERVED;
         res.served_track     = queue_track[pos];
         res.served_requester = queue_owner[pos];
         head_position        = queue_track[pos];
         owes_entry[queue_owner[pos]] = 1'b0;
         for (i = pos; i + 1 < queued; i++) begin
            queue_track[i] = queue_track[i + 1];
            queue_owner[i] = queue_owner[i + 1];
         end
         queued--;
         res.queue_count = COUNT_W'(queued);
         res.last        = 1'b1;
         post_result(res);
      end else if (item.mode != MODE_REQUEST) begin
         res             = '0;
         res.kind        = KIND_NONE;
         res.queue_count = COUNT_W'(queued);
         res.last        = 1'b1;
         post_result(res);
      end
   endtask

   // ---------------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------------

   function automatic string describe(rsp_type r);
      return $sformatf("kind=%0d track=%0d requester=%0d count=%0d last=%0d",
                       r.kind, r.served_track, r.served_requester, r.queue_count, r.last);
   endfunction

   // Results cannot be held off, so every strobe is a transfer.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected result: expected nothing, actual %s",
                     $time, describe(rsp_data));
         end else begin
            oldest_result = pending_results.pop_front();
            if (rsp_data.kind !== oldest_result.kind ||
                rsp_data.served_track !== oldest_result.served_track ||
                rsp_data.served_requester !== oldest_result.served_requester ||
                rsp_data.queue_count !== oldest_result.queue_count ||
                rsp_data.last !== oldest_result.last) begin
               mismatch_count++;
               $display("%0t: result mismatch: expected %s", $time, describe(oldest_result));
               $display("%0t: result mismatch: actual   %s", $time, describe(rsp_data));
            end
         end
      end
   end

   // Restart the count on any item, result or register transfer.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (psel && penable && pwrite && pready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("sstf_disk_request_scheduler verification failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------------

   // Hold start and the item from a falling edge until the transfer; when no gap
   // is drawn, start stays high straight into the next item.
   task automatic send_item(input req_type item);
      int unsigned gap;
      gap = gapless ? 0 : $urandom_range(0, MAX_GAP);
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start    <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (busy) @(posedge clock);
      schedule_item(item);
   endtask

   // Drop start, wait for every predicted result and for busy to fall, then let
   // a trailing shift or recount finish.
   task automatic wait_idle();
      @(negedge clock);
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      @(posedge clock);
      while (busy) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Setup cycle, then access cycle; the register takes the value at the edge
   // where pready is seen.
   task automatic write_register(input logic reg_sel, input logic [CFG_W-1:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_sel, 2'b00};
      pwdata  <= DATA_W'(value);
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (reg_sel == REG_MAX_QUEUE) cfg_max_queue = value;
      else cfg_requesters = value;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic configure(input int unsigned limit, input int unsigned nreq);
      wait_idle();
      write_register(REG_MAX_QUEUE, CFG_W'(limit));
      write_register(REG_NUM_REQUESTERS, CFG_W'(nreq));
   endtask

   // ---------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------

   function automatic req_type make_item(logic [MODE_W-1:0] mode, logic [ID_W-1:0] id,
                                         logic [TRACK_W-1:0] track);
      req_type item;
      item.mode         = mode;
      item.requester_id = id;
      item.track        = track;
      return item;
   endfunction

   // Mostly random tracks; the rest repeat the extremes or sit close to the
   // head so that equal and equidistant seeks come up often.
   function automatic logic [TRACK_W-1:0] pick_track();
      logic [TRACK_W-1:0] track;
      case ($urandom_range(0, 3))
         0, 1: track = TRACK_W'($urandom_range(0, 65535));
         2: begin
            case ($urandom_range(0, 2))
               0: track = '0;
               1: track = '1;
               default: track = head_position;
            endcase
         end
         default: track = head_position + TRACK_W'($urandom_range(0, 8)) - TRACK_W'(4);
      endcase
      return track;
   endfunction

   // Mostly requests from requesters that are free to ask, so the queue fills
   // and services follow; polls, stray ids and rare finish marks are the noise.
   function automatic req_type make_traffic_item();
      req_type     item;
      int unsigned nreq;
      int unsigned roll;
      int unsigned lo;
      int unsigned i;
      int unsigned free_ids[$];
      nreq              = clamp_setting(cfg_requesters, MAX_REQUESTERS);
      item.track        = pick_track();
      item.requester_id = ID_W'($urandom_range(0, MAX_REQUESTERS - 1));
      roll              = $urandom_range(0, 99);
      if (roll < 80) begin
         item.mode = MODE_REQUEST;
         for (i = 0; i < nreq; i++) begin
            if (!retired[i] && !owes_entry[i]) free_ids = {free_ids, i};
         end
         if (free_ids.size() > 0 && $urandom_range(0, 3) != 0)
            item.requester_id = ID_W'(free_ids[$urandom_range(0, free_ids.size() - 1)]);
         else if ($urandom_range(0, 1) == 1)
            item.requester_id = ID_W'($urandom_range(0, nreq - 1));
      end else if (roll < 88) begin
         item.mode = MODE_POLL;
      end else if (roll < 94) begin
         item.mode = MODE_SPARE;
      end else if (roll < 97) begin
         item.mode = MODE_FINISH;
         lo = (retire_floor > 0) ? retire_floor - 1 : 0;
         item.requester_id = ID_W'($urandom_range(lo, MAX_REQUESTERS - 1));
         if (retire_floor > 0 && item.requester_id == retire_floor - 1) retire_floor--;
      end else begin
         item.mode = MODE_REQUEST;
      end
      return item;
   endfunction

   // Small queue and requester set so that services, ties, stray ids and an
   // outstanding requester's second request all show up in a few items.
   task automatic test_queue_basics();
      configure(3, 4);
      send_item(make_item(MODE_POLL, 4'd0, 16'd0));           // empty queue, no service
      send_item(make_item(MODE_SPARE, 4'd15, 16'hFFFF));      // unused mode polls
      send_item(make_item(MODE_REQUEST, 4'd0, 16'hFFFF));
      send_item(make_item(MODE_REQUEST, 4'd0, 16'd5));        // already outstanding
      send_item(make_item(MODE_REQUEST, 4'd3, 16'd0));
      send_item(make_item(MODE_REQUEST, 4'd9, 16'd10));       // not taking part
      send_item(make_item(MODE_REQUEST, 4'd1, 16'd32768));    // full: serve track 0
      send_item(make_item(MODE_REQUEST, 4'd3, 16'd32768));    // equal tracks, oldest wins
      send_item(make_item(MODE_FINISH, 4'd9, 16'd0));         // ignored finish mark
      send_item(make_item(MODE_FINISH, 4'd15, 16'hFFFF));
      send_item(make_item(MODE_POLL, 4'd2, 16'd0));
      send_item(make_item(MODE_REQUEST, 4'd2, 16'd100));
      send_item(make_item(MODE_REQUEST, 4'd1, 16'd1));        // equidistant either side
      send_item(make_item(MODE_REQUEST, 4'd0, 16'hFFFF));
      send_item(make_item(MODE_REQUEST, 4'd15, 16'hFFFF));
      send_item(make_item(MODE_REQUEST, 4'd3, 16'd12345));
      send_item(make_item(MODE_POLL, 4'd0, 16'd0));
      send_item(make_item(MODE_SPARE, 4'd0, 16'd0));
   endtask

   // One register setting, then random traffic with bursts of back-to-back
   // items mixed with random gaps.
   task automatic test_traffic_phase(input int unsigned limit, input int unsigned nreq);
      int unsigned n;
      configure(limit, nreq);
      for (n = 0; n < PHASE_ITEMS; n++) begin
         if (n % 40 == 0) gapless = ($urandom_range(0, 2) == 0);
         send_item(make_traffic_item());
      end
      gapless = 1'b0;
   endtask

   // Every requester asks, then all of them finish: once none is live the
   // queue drains one entry per item, and later requests are refused.
   task automatic test_full_drain();
      int unsigned i;
      configure(16, 16);
      for (i = 0; i < MAX_REQUESTERS; i++)
         send_item(make_item(MODE_REQUEST, ID_W'(i), pick_track()));
      for (i = MAX_REQUESTERS; i > 0; i--) begin
         send_item(make_item(MODE_FINISH, ID_W'(i - 1), pick_track()));
         if ($urandom_range(0, 1) == 1) send_item(make_item(MODE_POLL, 4'd0, pick_track()));
      end
      retire_floor = 0;
      for (i = 0; i < 6; i++)
         send_item(make_item(MODE_REQUEST, ID_W'($urandom_range(0, 15)), pick_track()));
      while (queued > 0) send_item(make_item(MODE_POLL, 4'd0, 16'd0));
      send_item(make_item(MODE_SPARE, 4'd7, 16'd0));
      send_item(make_item(MODE_POLL, 4'd0, 16'd0));
   endtask

   initial begin
      int unsigned p;
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      psel     = 1'b0;
      penable  = 1'b0;
      pwrite   = 1'b0;
      paddr    = '0;
      pwdata   = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_queue_basics();
      for (p = 0; p < NUM_PHASES; p++)
         test_traffic_phase(PHASE_MAX_QUEUE[p], PHASE_REQUESTERS[p]);
      test_full_drain();

      wait_idle();
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("sstf_disk_request_scheduler verification clean");
      end else begin
         $display("sstf_disk_request_scheduler verification failed");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/sdrs_pkg.sv
rtl/core/sdrs_ram.sv
rtl/core/sdrs_ctrl.sv
rtl/core/sdrs_dpath.sv
rtl/core/sstf_disk_request_scheduler.sv
sim/tb_sstf_disk_request_scheduler.sv
